// ----- hw/rtl/lfo_pkg.sv -----
// ----------------------------------------------------------------------------
// LFO package
// Shared widths, waveform codes, register indexes and the sine table.
// ----------------------------------------------------------------------------
package lfo_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned SquareHalfPeriod = 126;
  localparam int unsigned SquarePeriod = 2 * SquareHalfPeriod;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgWaveSel = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAmpDiv  = 1'd1;

  localparam logic [SampleW-1:0] Mid      = 8'd128;
  localparam logic [SampleW-1:0] TriTop   = 8'd254;
  localparam logic [SampleW-1:0] LevelLo  = 8'h01;
  localparam logic [SampleW-1:0] LevelMid = 8'h7F;
  localparam logic [SampleW-1:0] LevelHi  = 8'hFE;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_RSAW     = 3'd2,
    WAVE_TRI      = 3'd3,
    WAVE_SQ_POS   = 3'd4,
    WAVE_HOLD     = 3'd5,
    WAVE_SQ_NEG   = 3'd6,
    WAVE_SQ_FULL  = 3'd7
  } wave_e;

  localparam logic [SampleW-1:0] SineRom [TableDepth] = '{
    8'h80,8'h83,8'h86,8'h89,8'h8c,8'h8f,8'h92,8'h95,8'h98,8'h9c,8'h9f,8'ha2,8'ha5,8'ha8,8'hab,8'hae,
    8'hb0,8'hb3,8'hb6,8'hb9,8'hbc,8'hbf,8'hc1,8'hc4,8'hc7,8'hc9,8'hcc,8'hce,8'hd1,8'hd3,8'hd5,8'hd8,
    8'hda,8'hdc,8'hde,8'he0,8'he2,8'he4,8'he6,8'he8,8'hea,8'hec,8'hed,8'hef,8'hf0,8'hf2,8'hf3,8'hf5,
    8'hf6,8'hf7,8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfc,8'hfd,8'hfe,8'hfe,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hfe,8'hfe,8'hfd,8'hfc,8'hfc,8'hfb,8'hfa,8'hf9,8'hf8,8'hf7,
    8'hf6,8'hf5,8'hf3,8'hf2,8'hf0,8'hef,8'hed,8'hec,8'hea,8'he8,8'he6,8'he4,8'he2,8'he0,8'hde,8'hdc,
    8'hda,8'hd8,8'hd5,8'hd3,8'hd1,8'hce,8'hcc,8'hc9,8'hc7,8'hc4,8'hc1,8'hbf,8'hbc,8'hb9,8'hb6,8'hb3,
    8'hb0,8'hae,8'hab,8'ha8,8'ha5,8'ha2,8'h9f,8'h9c,8'h98,8'h95,8'h92,8'h8f,8'h8c,8'h89,8'h86,8'h83,
    8'h80,8'h7c,8'h79,8'h76,8'h73,8'h70,8'h6d,8'h6a,8'h67,8'h63,8'h60,8'h5d,8'h5a,8'h57,8'h54,8'h51,
    8'h4f,8'h4c,8'h49,8'h46,8'h43,8'h40,8'h3e,8'h3b,8'h38,8'h36,8'h33,8'h31,8'h2e,8'h2c,8'h2a,8'h27,
    8'h25,8'h23,8'h21,8'h1f,8'h1d,8'h1b,8'h19,8'h17,8'h15,8'h13,8'h12,8'h10,8'h0f,8'h0d,8'h0c,8'h0a,
    8'h09,8'h08,8'h07,8'h06,8'h05,8'h04,8'h03,8'h03,8'h02,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h03,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,
    8'h09,8'h0a,8'h0c,8'h0d,8'h0f,8'h10,8'h12,8'h13,8'h15,8'h17,8'h19,8'h1b,8'h1d,8'h1f,8'h21,8'h23,
    8'h25,8'h27,8'h2a,8'h2c,8'h2e,8'h31,8'h33,8'h36,8'h38,8'h3b,8'h3e,8'h40,8'h43,8'h46,8'h49,8'h4c,
    8'h4f,8'h51,8'h54,8'h57,8'h5a,8'h5d,8'h60,8'h63,8'h67,8'h6a,8'h6d,8'h70,8'h73,8'h76,8'h79,8'h7c
  };

endpackage

// ----- hw/rtl/lfo_div.sv -----
// ----------------------------------------------------------------------------
// LFO serial divider
// Restoring unsigned divider, one quotient bit per cycle. Divisor nonzero.
// ----------------------------------------------------------------------------
module lfo_div #(
  parameter int unsigned Width = lfo_pkg::SampleW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(Width - 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] rem_q, quo_q, div_q;
  logic [Width:0]   rem_shift;
  logic             fits;

  assign rem_shift = {rem_q, quo_q[Width-1]};
  assign fits      = rem_shift >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? Width'(rem_shift - {1'b0, div_q}) : rem_shift[Width-1:0];
      quo_q <= {quo_q[Width-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) && !start_i |-> done_q) else $error("divider finished without done");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held longer than one cycle");

endmodule

// ----- hw/rtl/lfo_multi_waveform_generator_top.sv -----
// ----------------------------------------------------------------------------
// LFO multi-waveform generator
// One tick in, one 8-bit level out, selected from eight waveforms.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with random_byte_i; one transaction
// is one LFO tick. Output channel: out_valid_o / out_stall_i with sample_o;
// exactly one result per tick, in order.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 wave select,
// 1 amplitude divisor); write only while idle.
// Sine ticks run two passes of the serial divider (table value / divisor,
// then 128 / divisor) before the result is formed. All other waveforms
// compute the result when the tick is accepted; it then passes through
// ST_DONE into the output register. One tick is in flight at a time;
// in_stall_o is high while busy.
// A result may wait in the output register under stall while the next tick
// is accepted; that tick holds at its end until the register frees.
// Reset: phase 0, triangle rising, wave select square pos, divisor 1.
// ----------------------------------------------------------------------------
module lfo_multi_waveform_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lfo_pkg::SampleW-1:0]  random_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lfo_pkg::SampleW-1:0]  sample_o
);

  localparam int unsigned W = lfo_pkg::SampleW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_VAL,
    ST_DIV_BIAS,
    ST_DONE
  } state_e;

  state_e         state_q;
  logic [2:0]     wave_sel_q;
  logic [W-1:0]   amp_div_q;
  logic [W-1:0]   phase_q, phase_d;
  logic           tri_fall_q, tri_fall_d;
  logic [W-1:0]   res_q, res_d;
  logic [W-1:0]   quo_val_q;
  logic           out_valid_q;
  logic [W-1:0]   out_data_q;

  logic           in_acc;
  logic           out_free;
  logic [W-1:0]   div_eff;
  logic           div_start, div_busy, div_done;
  logic [W-1:0]   div_dividend, div_quo;
  logic [W-1:0]   sq_cnt;
  logic           sq_low;
  logic [W-1:0]   rom_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_eff    = (amp_div_q == '0) ? W'(1) : amp_div_q;
  assign rom_val    = lfo_pkg::SineRom[W'(int'(phase_q) % lfo_pkg::TableDepth)];

  assign sq_cnt = phase_q + 1'b1;
  assign sq_low = 32'(sq_cnt) < lfo_pkg::SquareHalfPeriod;

  always_comb begin
    phase_d    = phase_q;
    tri_fall_d = tri_fall_q;
    res_d      = '0;
    case (lfo_pkg::wave_e'(wave_sel_q))
      lfo_pkg::WAVE_SINE: begin
        phase_d = W'((int'(phase_q) + 1) % lfo_pkg::TableDepth);
      end
      lfo_pkg::WAVE_SAW: begin
        phase_d = phase_q + 1'b1;
        res_d   = phase_d;
      end
      lfo_pkg::WAVE_RSAW: begin
        phase_d = phase_q - 1'b1;
        res_d   = phase_d;
      end
      lfo_pkg::WAVE_TRI: begin
        if (tri_fall_q) begin
          phase_d = phase_q - W'(2);
          if (phase_d == '0) tri_fall_d = 1'b0;
        end else begin
          phase_d = phase_q + W'(2);
          if (phase_d == lfo_pkg::TriTop) tri_fall_d = 1'b1;
        end
        res_d = phase_d;
      end
      lfo_pkg::WAVE_HOLD: begin
        res_d = random_byte_i;
      end
      default: begin
        phase_d = (32'(sq_cnt) >= lfo_pkg::SquarePeriod)
                  ? W'(32'(sq_cnt) - lfo_pkg::SquarePeriod) : sq_cnt;
        case (lfo_pkg::wave_e'(wave_sel_q))
          lfo_pkg::WAVE_SQ_POS: res_d = sq_low ? lfo_pkg::LevelMid : lfo_pkg::LevelHi;
          lfo_pkg::WAVE_SQ_NEG: res_d = sq_low ? lfo_pkg::LevelLo : lfo_pkg::LevelMid;
          default:              res_d = sq_low ? lfo_pkg::LevelLo : lfo_pkg::LevelHi;
        endcase
      end
    endcase
  end

  assign div_start = (in_acc && (wave_sel_q == lfo_pkg::WAVE_SINE))
                  || ((state_q == ST_DIV_VAL) && div_done);
  assign div_dividend = (state_q == ST_IDLE) ? rom_val : lfo_pkg::Mid;

  lfo_div #(
    .Width (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q <= lfo_pkg::WAVE_SQ_POS;
      amp_div_q  <= W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfo_pkg::CfgWaveSel: wave_sel_q <= cfg_data_i[2:0];
        lfo_pkg::CfgAmpDiv:  amp_div_q  <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      tri_fall_q  <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      quo_val_q   <= '0;
      out_data_q  <= '0;
    end else begin
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)                out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            phase_q    <= phase_d;
            tri_fall_q <= tri_fall_d;
            res_q      <= res_d;
            state_q    <= (wave_sel_q == lfo_pkg::WAVE_SINE) ? ST_DIV_VAL : ST_DONE;
          end
        end
        ST_DIV_VAL: begin
          if (div_done) begin
            quo_val_q <= div_quo;
            state_q   <= ST_DIV_BIAS;
          end
        end
        ST_DIV_BIAS: begin
          if (div_done) begin
            res_q   <= quo_val_q + lfo_pkg::Mid - div_quo;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_data_q;

  a_div_in_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV_VAL || state_q == ST_DIV_BIAS))
    else $error("divider running outside sine sequence");
  a_done_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_VAL || state_q == ST_DIV_BIAS))
    else $error("divider result with no consumer");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result issued outside done state");

endmodule
